### src/pfbc_pkg.sv
// Package with the shared types, constants and helper functions of the paged flash byte cache.
package pfbc_pkg;

  localparam int unsigned BUFFER_BYTES = 1024;
  localparam int unsigned MAX_PAGES    = 8192;
  localparam int unsigned BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [1:0]  SEL_RESET   = 2'd0;
  localparam logic [13:0] TOTAL_RESET = 14'd4096;

  // Configuration register byte addresses.
  localparam logic [2:0] ADDR_PAGE_SIZE_SEL = 3'd0;
  localparam logic [2:0] ADDR_PAGE_TOTAL    = 3'd4;

  typedef enum logic [2:0] {
    OP_OPEN  = 3'd0,
    OP_SEEK  = 3'd1,
    OP_READ  = 3'd2,
    OP_WRITE = 3'd3,
    OP_CLOSE = 3'd4,
    OP_DRAIN = 3'd5,
    OP_FILL  = 3'd6,
    OP_DONE  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MODE    = 3'd1,
    ST_EOF     = 3'd2,
    ST_BUSY    = 3'd3,
    ST_SEEK_IG = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_PROGRAM = 2'd1,
    REQ_LOAD    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_PROG_ENTER = 2'd1,
    PH_LOAD       = 2'd2,
    PH_PROG_CLOSE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    WH_START   = 2'd0,
    WH_CURRENT = 2'd1,
    WH_END     = 2'd2
  } whence_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_EXEC  = 2'd1,
    BK_CLEAR = 2'd2
  } back_state_e;

  // Mode flag bits.
  localparam int unsigned MF_READ  = 0;
  localparam int unsigned MF_WRITE = 1;
  localparam int unsigned MF_MOD   = 2;

  typedef struct packed {
    op_e                op;
    logic [1:0]         open_mode;
    logic [1:0]         whence;
    logic signed [24:0] seek_offset;
    logic [7:0]         data_in;
    logic [9:0]         buffer_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [23:0] position;
    logic [1:0]  request_kind;
    logic [12:0] request_page;
  } result_t;

  typedef struct packed {
    logic [1:0]  page_size_sel;
    logic [13:0] page_total;
  } cfg_t;

  // Page shift in bits, limited to the buffer size.
  function automatic logic [3:0] page_shift(input logic [1:0] sel);
    logic [3:0] sh;
    sh = (sel == 2'd1) ? 4'd9 : ((sel == 2'd2) ? 4'd10 : 4'd8);
    if (sh > 4'(BUF_AW)) begin
      sh = 4'(BUF_AW);
    end
    return sh;
  endfunction

  // Page count limited to the largest supported device.
  function automatic logic [13:0] eff_pages(input logic [13:0] total);
    logic [13:0] t;
    t = total;
    if (t > 14'(MAX_PAGES)) begin
      t = 14'(MAX_PAGES);
    end
    return t;
  endfunction

endpackage

### src/paged_flash_byte_cache.sv
// Top level of the paged flash byte cache: queues, executor and configuration registers.
//
// Usage: stream items (open, seek, read, write, close, drain, fill, done) are
// pushed into the input queue with push while full is low. Each item gives
// exactly one result, presented on the result ports while empty is low and
// taken with pop. Program and load requests in the results are carried out
// by an external agent with drain, fill and done items.
// In the executor an item goes through a buffer read and then the execute
// step, which depends on the registered read of the page buffer; the
// executor takes no new item until it has pushed the result of the last one.
// When a write-only stream enters a page, the executor sweeps 0xFF into the
// buffer, one byte a cycle, over the whole page.
// When the receiver stalls, the two-entry result queue fills, the executor
// holds, and the input queue fills and raises full.
// Reset clears the queues, closes the stream, sets the position to zero and
// loads the register defaults; the buffer contents stay undefined.
// The configuration port is APB-style with pready always high; page_size_sel
// lies at address 0 and page_total at address 4.
module paged_flash_byte_cache (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode_i,
  input  logic [1:0]         open_mode_i,
  input  logic [1:0]         whence_i,
  input  logic signed [24:0] seek_offset_i,
  input  logic [7:0]         data_in_i,
  input  logic [9:0]         buffer_index_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status_o,
  output logic [7:0]         data_out_o,
  output logic [23:0]        position_o,
  output logic [1:0]         request_kind_o,
  output logic [12:0]        request_page_o
);
  import pfbc_pkg::*;

  cfg_t    cfg_q;
  item_t   head;
  logic    q_empty, q_pop;
  logic    oq_full, oq_push;
  result_t oq_data, oq_head;
  logic    cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_size_sel <= SEL_RESET;
      cfg_q.page_total    <= TOTAL_RESET;
    end else if (cfg_wr) begin
      if (paddr == ADDR_PAGE_SIZE_SEL) begin
        cfg_q.page_size_sel <= pwdata[1:0];
      end else if (paddr == ADDR_PAGE_TOTAL) begin
        cfg_q.page_total <= pwdata[13:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    prdata = 32'd0;
    if (paddr == ADDR_PAGE_SIZE_SEL) begin
      prdata = {30'd0, cfg_q.page_size_sel};
    end else if (paddr == ADDR_PAGE_TOTAL) begin
      prdata = {18'd0, cfg_q.page_total};
    end
  end

  pfbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .opcode_i       (opcode_i),
    .open_mode_i    (open_mode_i),
    .whence_i       (whence_i),
    .seek_offset_i  (seek_offset_i),
    .data_in_i      (data_in_i),
    .buffer_index_i (buffer_index_i),
    .pop_i          (q_pop),
    .empty_o        (q_empty),
    .head_o         (head)
  );

  pfbc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_empty_i (q_empty),
    .in_head_i  (head),
    .in_pop_o   (q_pop),
    .out_full_i (oq_full),
    .out_push_o (oq_push),
    .out_data_o (oq_data)
  );

  pfbc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_data),
    .full_o  (oq_full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (oq_head)
  );

  assign status_o       = oq_head.status;
  assign data_out_o     = oq_head.data_out;
  assign position_o     = oq_head.position;
  assign request_kind_o = oq_head.request_kind;
  assign request_page_o = oq_head.request_page;

`ifndef SYNTHESIS
  // A shown result never carries an undefined request kind.
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (request_kind_o != 2'd3))
    else $error("request kind out of range");

  // A result without a request names page zero.
  a_page_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && request_kind_o == REQ_NONE) |-> (request_page_o == 13'd0))
    else $error("request page set without a request");

  // Only read and drain results carry data; a busy result carries no request.
  a_busy_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_BUSY) |-> (request_kind_o == REQ_NONE && data_out_o == 8'd0))
    else $error("busy result with side effects");
`endif

endmodule

### src/pfbc_front.sv
// Front part: accepts input items, decodes them and queues them for the back part.
module pfbc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [2:0]          opcode_i,
  input  logic [1:0]          open_mode_i,
  input  logic [1:0]          whence_i,
  input  logic signed [24:0]  seek_offset_i,
  input  logic [7:0]          data_in_i,
  input  logic [9:0]          buffer_index_i,
  input  logic                pop_i,
  output logic                empty_o,
  output pfbc_pkg::item_t     head_o
);
  import pfbc_pkg::*;

  item_t      mem_q [QUEUE_DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  item_t      item;
  logic       do_push, do_pop;

  // Decode the raw fields into an item.
  always_comb begin
    item.op           = op_e'(opcode_i);
    item.open_mode    = open_mode_i;
    item.whence       = whence_i;
    item.seek_offset  = seek_offset_i;
    item.data_in      = data_in_i;
    item.buffer_index = buffer_index_i;
  end

  assign full_o  = (cnt_q == 2'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### src/pfbc_outq.sv
// Result queue that parts the back part from the result receiver.
module pfbc_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfbc_pkg::result_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pfbc_pkg::result_t head_o
);
  import pfbc_pkg::*;

  result_t    mem_q [QUEUE_DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### src/pfbc_back.sv
// Back part: executes queued items against the page buffer and the stream state.
module pfbc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfbc_pkg::cfg_t    cfg_i,
  input  logic              in_empty_i,
  input  pfbc_pkg::item_t   in_head_i,
  output logic              in_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output pfbc_pkg::result_t out_data_o
);
  import pfbc_pkg::*;

  logic [7:0] buf_mem [BUFFER_BYTES];
  logic [7:0] rdata_q;

  back_state_e state_q, state_d;
  item_t       item_q;
  logic [23:0] pos_q, pos_d;
  logic [2:0]  mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [BUF_AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [3:0]        sh;
  logic [BUF_AW-1:0] mask;
  logic [13:0]       eff;
  logic [23:0]       size;
  logic [23:0]       cur_page;
  logic [BUF_AW-1:0] raddr;

  logic              we;
  logic [BUF_AW-1:0] waddr;
  logic [7:0]        wdata;

  logic signed [26:0] addr;
  logic [23:0]        base;
  logic               seek_ok;
  logic [BUF_AW-1:0]  offs;
  logic               do_change, do_enter, modified;
  logic [23:0]        old_pg, new_pg, enter_pg;
  logic [2:0]         mf;
  logic               clr_start;
  result_t            res;

  // Geometry derived from the configuration.
  always_comb begin
    sh       = page_shift(cfg_i.page_size_sel);
    mask     = BUF_AW'((BUFFER_BYTES - 1) >> (4'(BUF_AW) - sh));
    eff      = eff_pages(cfg_i.page_total);
    size     = {10'd0, eff} << sh;
    cur_page = pos_q >> sh;
    offs     = pos_q[BUF_AW-1:0] & mask;
  end

  // Read address for the item at the queue head.
  always_comb begin
    if (in_head_i.op == OP_READ || in_head_i.op == OP_WRITE) begin
      raddr = pos_q[BUF_AW-1:0] & mask;
    end else begin
      raddr = in_head_i.buffer_index[BUF_AW-1:0];
    end
  end

  // Page buffer with a registered read port; the read data is held until the next item.
  always_ff @(posedge clk_i) begin
    if (we) begin
      buf_mem[waddr] <= wdata;
    end
    if (in_pop_o) begin
      rdata_q <= buf_mem[raddr];
    end
  end

  // Execution of one item and the state sequencer.
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    mode_d     = mode_q;
    phase_d    = phase_q;
    clr_cnt_d  = clr_cnt_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    we         = 1'b0;
    waddr      = offs;
    wdata      = item_q.data_in;
    res        = '0;
    mf         = mode_q;
    do_change  = 1'b0;
    do_enter   = 1'b0;
    modified   = 1'b0;
    old_pg     = cur_page;
    new_pg     = cur_page;
    enter_pg   = cur_page;
    clr_start  = 1'b0;
    seek_ok    = 1'b0;
    base       = 24'd0;
    addr       = '0;

    case (state_q)
      BK_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          state_d  = BK_EXEC;
        end
      end

      BK_EXEC: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = BK_IDLE;
          if (item_q.op inside {OP_OPEN, OP_SEEK, OP_READ, OP_WRITE, OP_CLOSE}
              && phase_q != PH_IDLE) begin
            res.status = ST_BUSY;
          end else begin
            case (item_q.op)
              OP_OPEN: begin
                mf       = {1'b0, item_q.open_mode};
                pos_d    = 24'd0;
                do_enter = 1'b1;
                enter_pg = 24'd0;
              end
              OP_SEEK: begin
                if (item_q.whence == WH_CURRENT) begin
                  base = pos_q;
                end else if (item_q.whence == WH_END) begin
                  base = size;
                end
                addr    = $signed({3'd0, base}) + $signed({{2{item_q.seek_offset[24]}},
                                                           item_q.seek_offset});
                seek_ok = !addr[26] && (addr[25:0] < {2'd0, size});
                if (seek_ok) begin
                  pos_d     = addr[23:0];
                  do_change = 1'b1;
                  new_pg    = addr[23:0] >> sh;
                end else begin
                  res.status = ST_SEEK_IG;
                end
              end
              OP_READ, OP_WRITE: begin
                if (!(item_q.op == OP_READ ? mf[MF_READ] : mf[MF_WRITE])) begin
                  res.status = ST_MODE;
                end else if (pos_q >= size) begin
                  res.status = ST_EOF;
                end else begin
                  if (item_q.op == OP_READ) begin
                    res.data_out = rdata_q;
                  end else if (rdata_q != item_q.data_in || !mf[MF_READ]) begin
                    we         = 1'b1;
                    mf[MF_MOD] = 1'b1;
                  end
                  pos_d = pos_q + 24'd1;
                  if (offs == mask) begin
                    do_change = 1'b1;
                    new_pg    = cur_page + 24'd1;
                  end
                end
              end
              OP_CLOSE: begin
                if (mf[MF_WRITE] && mf[MF_MOD] && cur_page < {10'd0, eff}) begin
                  res.request_kind = REQ_PROGRAM;
                  res.request_page = cur_page[12:0];
                  phase_d          = PH_PROG_CLOSE;
                end
                mf = 3'd0;
              end
              OP_DRAIN: begin
                res.data_out = rdata_q;
              end
              OP_FILL: begin
                if (phase_q == PH_LOAD) begin
                  we    = 1'b1;
                  waddr = item_q.buffer_index[BUF_AW-1:0];
                end else begin
                  res.status = ST_MODE;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                if (phase_q == PH_PROG_ENTER) begin
                  do_enter = 1'b1;
                end
              end
            endcase

            // Page change: program the old page first when it holds changes.
            if (do_change && old_pg != new_pg) begin
              modified   = mf[MF_MOD];
              mf[MF_MOD] = 1'b0;
              if (modified && mf[MF_WRITE] && old_pg < {10'd0, eff}) begin
                res.request_kind = REQ_PROGRAM;
                res.request_page = old_pg[12:0];
                phase_d          = PH_PROG_ENTER;
              end else begin
                do_enter = 1'b1;
                enter_pg = new_pg;
              end
            end

            // Enter a page: when readable, load it if it lies on the device; else clear the buffer.
            if (do_enter) begin
              if (mf[MF_READ]) begin
                if (enter_pg < {10'd0, eff}) begin
                  res.request_kind = REQ_LOAD;
                  res.request_page = enter_pg[12:0];
                  phase_d          = PH_LOAD;
                end
              end else begin
                clr_start = 1'b1;
              end
            end
          end
          res.position = pos_d;
          mode_d       = mf;
          if (clr_start) begin
            state_d   = BK_CLEAR;
            clr_cnt_d = '0;
          end
        end
      end

      BK_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = 8'hFF;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == mask) begin
          state_d = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign out_data_o = res;

  // Latched item under execution.
  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      item_q <= in_head_i;
    end
  end

  // Control and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      pos_q     <= 24'd0;
      mode_q    <= 3'd0;
      phase_q   <= PH_IDLE;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule

### tb/sv/paged_flash_byte_cache_checker.sv
// Checker for the paged flash byte cache: predicts every result and compares it.
`timescale 1ns / 1ps

module paged_flash_byte_cache_checker
  import pfbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               push,
  input  logic               full,
  input  logic [2:0]         opcode_i,
  input  logic [1:0]         open_mode_i,
  input  logic [1:0]         whence_i,
  input  logic signed [24:0] seek_offset_i,
  input  logic [7:0]         data_in_i,
  input  logic [9:0]         buffer_index_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [2:0]         status_o,
  input  logic [7:0]         data_out_o,
  input  logic [23:0]        position_o,
  input  logic [1:0]         request_kind_o,
  input  logic [12:0]        request_page_o,
  output int                 errors_o,
  output int                 pending_o
);

  // Shadow of the registers and of the cache state.
  logic [1:0]  sel_q;
  logic [13:0] total_q;
  logic [2:0]  flags_q;
  logic [23:0] pos_q;
  logic [7:0]  page_buf [BUFFER_BYTES];
  phase_e      phase_q;
  logic [13:0] pend_q;
  result_t     awaited_q[$];

  function automatic int shift_now();
    int sh;
    sh = (sel_q == 2'd1) ? 9 : ((sel_q == 2'd2) ? 10 : 8);
    if ((1 << sh) > BUFFER_BYTES) sh = $clog2(BUFFER_BYTES);
    return sh;
  endfunction

  function automatic int pages_now();
    return (total_q > MAX_PAGES) ? MAX_PAGES : int'(total_q);
  endfunction

  // Request a load of the page when readable and on the device, or sweep 0xFF when the stream is not readable.
  function automatic void enter_page(input int page, inout result_t r);
    if (flags_q[MF_READ]) begin
      if (page < pages_now()) begin
        r.request_kind = REQ_LOAD;
        r.request_page = page[12:0];
        pend_q = page[13:0];
        phase_q = PH_LOAD;
      end
    end else begin
      for (int i = 0; i < (1 << shift_now()); i++) page_buf[i] = 8'hff;
    end
  endfunction

  // Program the old page first when it holds modified data.
  function automatic void switch_page(input int old_pg, input int new_pg, inout result_t r);
    logic was_mod;
    was_mod = flags_q[MF_MOD];
    if (old_pg == new_pg) return;
    flags_q[MF_MOD] = 1'b0;
    if (was_mod && flags_q[MF_WRITE] && old_pg < pages_now()) begin
      r.request_kind = REQ_PROGRAM;
      r.request_page = old_pg[12:0];
      pend_q = old_pg[13:0];
      phase_q = PH_PROG_ENTER;
      return;
    end
    enter_page(new_pg, r);
  endfunction

  function automatic result_t cache_step(input logic [2:0] op, input logic [1:0] om,
                                         input logic [1:0] wh, input logic signed [24:0] off,
                                         input logic [7:0] din, input logic [9:0] idx);
    result_t r;
    int      sh;
    int      span;
    int      mask;
    int      o;
    int      pg;
    longint  addr;
    r = '0;
    sh = shift_now();
    span = pages_now() << sh;
    mask = (1 << sh) - 1;
    if (op <= OP_CLOSE && phase_q != PH_IDLE) begin
      r.status = ST_BUSY;
    end else begin
      case (op)
        OP_OPEN: begin
          flags_q = {1'b0, om};
          pos_q = '0;
          enter_page(0, r);
        end
        OP_SEEK: begin
          if (wh == WH_CURRENT) addr = longint'(pos_q) + longint'(off);
          else if (wh == WH_END) addr = longint'(span) + longint'(off);
          else addr = longint'(off);
          if (addr >= 0 && addr < span) begin
            pg = pos_q >> sh;
            pos_q = addr[23:0];
            switch_page(pg, int'(pos_q) >> sh, r);
          end else begin
            r.status = ST_SEEK_IG;
          end
        end
        OP_READ, OP_WRITE: begin
          if (!flags_q[(op == OP_READ) ? MF_READ : MF_WRITE]) begin
            r.status = ST_MODE;
          end else if (pos_q >= span) begin
            r.status = ST_EOF;
          end else begin
            o = pos_q & mask;
            pg = pos_q >> sh;
            if (op == OP_READ) begin
              r.data_out = page_buf[o];
            end else if (page_buf[o] != din || !flags_q[MF_READ]) begin
              page_buf[o] = din;
              flags_q[MF_MOD] = 1'b1;
            end
            pos_q = pos_q + 24'd1;
            if (o == mask) switch_page(pg, pg + 1, r);
          end
        end
        OP_CLOSE: begin
          pg = pos_q >> sh;
          if (flags_q[MF_WRITE] && flags_q[MF_MOD] && pg < pages_now()) begin
            r.request_kind = REQ_PROGRAM;
            r.request_page = pg[12:0];
            pend_q = pg[13:0];
            phase_q = PH_PROG_CLOSE;
          end
          flags_q = '0;
        end
        OP_DRAIN: r.data_out = page_buf[idx];
        OP_FILL: begin
          if (phase_q == PH_LOAD) page_buf[idx] = din;
          else r.status = ST_MODE;
        end
        default: begin
          if (phase_q == PH_PROG_ENTER) begin
            phase_q = PH_IDLE;
            enter_page(int'(pos_q) >> sh, r);
          end else begin
            phase_q = PH_IDLE;
          end
        end
      endcase
    end
    r.position = pos_q;
    return r;
  endfunction

  assign pending_o = awaited_q.size();

  // Track register writes, predict accepted items and check popped results.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      sel_q = SEL_RESET;
      total_q = TOTAL_RESET;
      flags_q = '0;
      pos_q = '0;
      phase_q = PH_IDLE;
      pend_q = '0;
      awaited_q.delete();
      errors_o <= 0;
      for (int i = 0; i < BUFFER_BYTES; i++) page_buf[i] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_PAGE_SIZE_SEL) sel_q = pwdata[1:0];
        else if (paddr == ADDR_PAGE_TOTAL) total_q = pwdata[13:0];
      end
      if (push && !full) begin
        awaited_q.push_back(cache_step(opcode_i, open_mode_i, whence_i, seek_offset_i,
                                       data_in_i, buffer_index_i));
      end
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result at %0t", $realtime);
          errors_o <= errors_o + 1;
        end else begin
          want = awaited_q.pop_front();
          if (status_o !== want.status || data_out_o !== want.data_out ||
              position_o !== want.position || request_kind_o !== want.request_kind ||
              request_page_o !== want.request_page) begin
            if (errors_o < 10)
              $display("mismatch at %0t: expected st %0d data %h pos %0d req %0d/%0d, got st %0d data %h pos %0d req %0d/%0d",
                       $realtime, want.status, want.data_out, want.position,
                       want.request_kind, want.request_page, status_o, data_out_o,
                       position_o, request_kind_o, request_page_o);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

### tb/sv/paged_flash_byte_cache_tb.sv
// Testbench top for the paged flash byte cache: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module paged_flash_byte_cache_tb;
  import pfbc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1100;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               push = 1'b0, full, empty, pop = 1'b0;
  logic [2:0]         opcode_i = '0;
  logic [1:0]         open_mode_i = '0, whence_i = '0;
  logic signed [24:0] seek_offset_i = '0;
  logic [7:0]         data_in_i = '0;
  logic [9:0]         buffer_index_i = '0;
  logic [2:0]         status_o;
  logic [7:0]         data_out_o;
  logic [23:0]        position_o;
  logic [1:0]         request_kind_o;
  logic [12:0]        request_page_o;
  int                 errors, pending;
  int                 idle_cycles = 0;
  int                 flash_span;
  logic               hold_go = 1'b0;

  paged_flash_byte_cache uut (.*);
  paged_flash_byte_cache_checker checker_i (.errors_o(errors), .pending_o(pending), .*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls at a changing rate, plus one long hold-off.
  int rx_cyc = 0, rx_pct = 0, hold_left = 0;
  logic hold_used = 1'b0;
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 80);
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 400;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("** paged_flash_byte_cache: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains all results, waits out a possible 0xFF sweep, then sets the page geometry.
  task automatic set_geometry(input logic [1:0] sel, input logic [13:0] total);
    int sh;
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write(ADDR_PAGE_SIZE_SEL, {30'd0, sel});
    reg_write(ADDR_PAGE_TOTAL, {18'd0, total});
    sh = (sel == 2'd1) ? 9 : ((sel == 2'd2) ? 10 : 8);
    flash_span = ((total > MAX_PAGES) ? MAX_PAGES : int'(total)) << sh;
  endtask

  task automatic send_item(input op_e op, input logic [1:0] om, input logic [1:0] wh,
                           input logic signed [24:0] off, input logic [7:0] din,
                           input logic [9:0] idx);
    push <= 1'b1;
    opcode_i <= op;
    open_mode_i <= om;
    whence_i <= wh;
    seek_offset_i <= off;
    data_in_i <= din;
    buffer_index_i <= idx;
    do @(posedge clk_i); while (full);
  endtask

  // Random items in bursts; mostly stream traffic with frequent transfer ends.
  task automatic random_items(input int count);
    int          burst, gap, pick;
    op_e         op;
    logic [1:0]  wh;
    logic [24:0] off;
    burst = $urandom_range(1, 20);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) op = OP_READ;
      else if (pick < 50) op = OP_WRITE;
      else if (pick < 62) op = OP_SEEK;
      else if (pick < 74) op = OP_DONE;
      else if (pick < 82) op = OP_DRAIN;
      else if (pick < 92) op = OP_FILL;
      else if (pick < 96) op = OP_OPEN;
      else op = OP_CLOSE;
      wh = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: off = 25'($urandom);
        1, 2, 3: off = 25'($urandom_range(0, 600)) - 25'd300;
        4, 5: off = 25'(flash_span) - 25'($urandom_range(0, 1200));
        default: off = (wh == WH_END) ? -25'($urandom_range(1, 1100))
                                      : 25'($urandom_range(0, flash_span + 40));
      endcase
      send_item(op, 2'($urandom), wh, off, 8'($urandom), 10'($urandom));
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Large pages first: a write-only open sweeps the whole buffer.
    set_geometry(2'd2, 14'd4096);
    send_item(OP_OPEN, 2'd2, WH_START, '0, '0, '0);
    send_item(OP_READ, '0, WH_START, '0, '0, '0);
    send_item(OP_WRITE, '0, WH_START, '0, 8'ha5, '0);
    send_item(OP_SEEK, '0, WH_START, 25'sd16777215, '0, '0);
    send_item(OP_SEEK, '0, WH_START, -25'sd16777216, '0, '0);
    send_item(OP_SEEK, '0, WH_END, -25'sd1, '0, '0);
    send_item(OP_READ, '0, WH_START, '0, '0, '0);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    send_item(OP_CLOSE, '0, WH_START, '0, '0, '0);
    send_item(OP_FILL, '0, WH_START, '0, 8'h11, 10'd5);
    send_item(OP_DRAIN, '0, WH_START, '0, '0, 10'd1023);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    send_item(OP_OPEN, 2'd0, WH_START, '0, '0, '0);
    send_item(OP_WRITE, '0, WH_START, '0, 8'h3c, '0);
    send_item(OP_OPEN, 2'd3, WH_START, '0, '0, '0);
    send_item(OP_FILL, '0, WH_START, '0, 8'h00, 10'd0);
    send_item(OP_FILL, '0, WH_START, '0, 8'hff, 10'd1023);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    send_item(OP_SEEK, '0, 2'd3, 25'sd5, '0, '0);
    send_item(OP_SEEK, '0, WH_CURRENT, -25'sd6, '0, '0);
    send_item(OP_WRITE, '0, WH_START, '0, 8'h77, '0);
    send_item(OP_CLOSE, '0, WH_START, '0, '0, '0);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    hold_go <= 1'b1;
    random_items(400);

    // One small page: crossing the last page with read-write and write-only streams.
    set_geometry(2'd0, 14'd1);
    send_item(OP_OPEN, 2'd3, WH_START, '0, '0, '0);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    send_item(OP_SEEK, '0, WH_END, -25'sd1, '0, '0);
    send_item(OP_WRITE, '0, WH_START, '0, 8'h5a, '0);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    send_item(OP_READ, '0, WH_START, '0, '0, '0);
    send_item(OP_WRITE, '0, WH_START, '0, 8'h01, '0);
    send_item(OP_OPEN, 2'd2, WH_START, '0, '0, '0);
    send_item(OP_SEEK, '0, WH_END, -25'sd1, '0, '0);
    send_item(OP_WRITE, '0, WH_START, '0, 8'h02, '0);
    send_item(OP_DONE, '0, WH_START, '0, '0, '0);
    random_items(400);

    // Page size select of 3 and a page total above the device limit.
    set_geometry(2'd3, 14'd16383);
    random_items(400);

    set_geometry(2'd1, 14'd8192);
    random_items(400);

    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("** paged_flash_byte_cache: PASSED **");
    else $display("** paged_flash_byte_cache: FAILED **");
    $finish;
  end

endmodule
